// ===== rtl/core/rbia_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rbia_pkg;

  // Payload widths
  localparam int ID_W       = 10;
  localparam int LIMIT_W    = 11;
  localparam int TDATA_W    = 16;

  // Defaults
  localparam int MAX_IDS_DEF  = 1024;
  localparam int ID_LIMIT_RST = 1024;

  // Free-mark store is organized in rows of ROW_W bits
  localparam int ROW_W = 32;
  localparam int BIT_W = 5;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REL_RD,
    ST_REL_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_ALLOC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clr_we;
    logic latch_in;
    logic rel_rd;
    logic rel_commit;
    logic scan_rd;
    logic scan_commit;
    logic scan_next;
    logic alloc_commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic kind_rel;
    logic frag_scan;
    logic in_window;
    logic scan_hit;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/rbia_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rbia_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rbia_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rbia_dp #(
  parameter int MAX_IDS = rbia_pkg::MAX_IDS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [rbia_pkg::TDATA_W-1:0]  s_tdata,
  input  wire logic [0:0]                    s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [rbia_pkg::TDATA_W-1:0]  m_tdata,
  output logic      [0:0]                    m_tuser,
  input  wire logic                          cfg_we,
  input  wire logic [rbia_pkg::LIMIT_W-1:0]  cfg_wdata,
  input  wire rbia_pkg::cmd_t                cmd,
  output rbia_pkg::stat_t                    stat
);

  localparam int ROW_W    = rbia_pkg::ROW_W;
  localparam int BIT_W    = rbia_pkg::BIT_W;
  localparam int ID_W     = rbia_pkg::ID_W;
  localparam int LIMIT_W  = rbia_pkg::LIMIT_W;
  localparam int NUM_ROWS = (MAX_IDS + ROW_W - 1) / ROW_W;
  localparam int ROW_AW   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int XW       = BIT_W + ROW_AW;
  localparam int IW       = $clog2(MAX_IDS + 1);
  localparam int CW       = (IW > LIMIT_W) ? IW : LIMIT_W;

  logic [IW-1:0]      win_low;
  logic [IW-1:0]      win_high;
  logic               frag;
  logic [LIMIT_W-1:0] id_limit;
  logic [ID_W-1:0]    rid;
  logic [ROW_AW-1:0]  clr_row;
  logic [ROW_AW-1:0]  scan_row;
  logic [ID_W-1:0]    res_id;
  logic               res_status;

  logic [ROW_W-1:0]   ram_rdata;
  logic               ram_we;
  logic [ROW_AW-1:0]  ram_waddr;
  logic [ROW_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [ROW_AW-1:0]  ram_raddr;

  logic [XW-1:0]      low_x;
  logic [XW-1:0]      top_x;
  logic [XW-1:0]      rid_x;
  logic [CW-1:0]      rid_c;
  logic [CW-1:0]      rid_c1;
  logic [CW-1:0]      low_c;
  logic [CW-1:0]      high_c;
  logic [CW-1:0]      lim_c;
  logic               at_low;
  logic               at_top;
  logic               grow_down;
  logic               grow_up;
  logic [ROW_W-1:0]   rel_row;
  logic [ROW_W-1:0]   lo_mask;
  logic [ROW_W-1:0]   hi_mask;
  logic [ROW_W-1:0]   masked;
  logic [BIT_W-1:0]   hit_bit;
  logic [ROW_W-1:0]   scan_wdata;
  logic [XW-1:0]      grant_x;

  assign low_x  = XW'(win_low);
  assign top_x  = XW'(win_high - IW'(1));
  assign rid_x  = XW'(rid);
  assign rid_c  = CW'(rid);
  assign rid_c1 = rid_c + CW'(1);
  assign low_c  = CW'(win_low);
  assign high_c = CW'(win_high);
  assign lim_c  = (CW'(id_limit) > CW'(MAX_IDS)) ? CW'(MAX_IDS) : CW'(id_limit);

  assign at_low    = (rid_c == low_c);
  assign at_top    = (rid_c1 == high_c);
  assign grow_down = (win_low != '0);
  assign grow_up   = (high_c < lim_c);

  // release: set the mark for an interior id, clear it at either end
  always_comb begin
    rel_row          = ram_rdata;
    rel_row[rid_x[BIT_W-1:0]] = !(at_low || at_top);
  end

  // scan: keep only bits of the current row inside [low, high)
  assign lo_mask = (scan_row == low_x[XW-1:BIT_W]) ?
                   ({ROW_W{1'b1}} << low_x[BIT_W-1:0]) : {ROW_W{1'b1}};
  assign hi_mask = (scan_row == top_x[XW-1:BIT_W]) ?
                   ({ROW_W{1'b1}} >> (BIT_W'(ROW_W - 1) - top_x[BIT_W-1:0])) :
                   {ROW_W{1'b1}};
  assign masked  = ram_rdata & lo_mask & hi_mask;

  always_comb begin
    hit_bit = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (masked[i]) begin
        hit_bit = BIT_W'(i);
      end
    end
  end

  always_comb begin
    scan_wdata          = ram_rdata;
    scan_wdata[hit_bit] = 1'b0;
  end

  assign grant_x = {scan_row, hit_bit};

  // mark store port selection
  assign ram_we    = cmd.clr_we | cmd.rel_commit | cmd.scan_commit;
  assign ram_waddr = cmd.clr_we ? clr_row :
                     cmd.rel_commit ? rid_x[XW-1:BIT_W] : scan_row;
  assign ram_wdata = cmd.clr_we ? '0 : cmd.rel_commit ? rel_row : scan_wdata;
  assign ram_re    = cmd.rel_rd | cmd.scan_rd;
  assign ram_raddr = cmd.rel_rd ? rid_x[XW-1:BIT_W] : scan_row;

  rbia_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_ROWS)
  ) u_marks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // status to controller
  assign stat.clr_last  = (clr_row == ROW_AW'(NUM_ROWS - 1));
  assign stat.kind_rel  = (s_tuser[0] == rbia_pkg::KIND_RELEASE);
  assign stat.frag_scan = frag && (win_low < win_high);
  assign stat.in_window = (rid_c >= low_c) && (rid_c < high_c);
  assign stat.scan_hit  = |masked;
  assign stat.scan_last = (scan_row == top_x[XW-1:BIT_W]);
  assign stat.out_free  = !m_tvalid || m_tready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      win_low  <= '0;
      win_high <= '0;
      frag     <= 1'b0;
      id_limit <= LIMIT_W'(rbia_pkg::ID_LIMIT_RST);
      clr_row  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        id_limit <= cfg_wdata;
      end
      if (cmd.clr_we) begin
        clr_row <= clr_row + ROW_AW'(1);
      end
      if (cmd.rel_commit) begin
        if (at_low) begin
          win_low <= IW'(rid_c1);
        end else if (at_top) begin
          win_high <= IW'(rid_c);
        end else begin
          frag <= 1'b1;
        end
      end
      if (cmd.alloc_commit) begin
        frag <= 1'b0;
        if (grow_down) begin
          win_low <= win_low - IW'(1);
        end else if (grow_up) begin
          win_high <= win_high + IW'(1);
        end
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      rid        <= s_tdata[ID_W-1:0];
      res_id     <= '0;
      res_status <= rbia_pkg::STATUS_OK;
      scan_row   <= low_x[XW-1:BIT_W];
    end
    if (cmd.scan_next) begin
      scan_row <= scan_row + ROW_AW'(1);
    end
    if (cmd.scan_commit) begin
      res_id <= ID_W'(grant_x);
    end
    if (cmd.alloc_commit) begin
      if (grow_down) begin
        res_id <= ID_W'(win_low - IW'(1));
      end else if (grow_up) begin
        res_id <= ID_W'(win_high);
      end else begin
        res_status <= rbia_pkg::STATUS_EXHAUSTED;
      end
    end
    if (cmd.out_load) begin
      m_tdata    <= rbia_pkg::TDATA_W'(res_id);
      m_tuser[0] <= res_status;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rbia_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rbia_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire rbia_pkg::stat_t stat,
  output rbia_pkg::cmd_t       cmd
);

  rbia_pkg::state_t state;
  rbia_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbia_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rbia_pkg::ST_CLEAR: begin
        if (stat.clr_last) state_next = rbia_pkg::ST_IDLE;
      end
      rbia_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (stat.kind_rel)       state_next = rbia_pkg::ST_REL_RD;
          else if (stat.frag_scan) state_next = rbia_pkg::ST_SCAN_RD;
          else                     state_next = rbia_pkg::ST_ALLOC;
        end
      end
      rbia_pkg::ST_REL_RD: begin
        state_next = stat.in_window ? rbia_pkg::ST_REL_WR : rbia_pkg::ST_FINISH;
      end
      rbia_pkg::ST_REL_WR:  state_next = rbia_pkg::ST_FINISH;
      rbia_pkg::ST_SCAN_RD: state_next = rbia_pkg::ST_SCAN_CHK;
      rbia_pkg::ST_SCAN_CHK: begin
        priority if (stat.scan_hit) state_next = rbia_pkg::ST_FINISH;
        else if (stat.scan_last)    state_next = rbia_pkg::ST_ALLOC;
        else                        state_next = rbia_pkg::ST_SCAN_RD;
      end
      rbia_pkg::ST_ALLOC: state_next = rbia_pkg::ST_FINISH;
      rbia_pkg::ST_FINISH: begin
        if (stat.out_free) state_next = rbia_pkg::ST_IDLE;
      end
      default: state_next = rbia_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      rbia_pkg::ST_CLEAR: cmd.clr_we = 1'b1;
      rbia_pkg::ST_IDLE: begin
        s_tready     = 1'b1;
        cmd.latch_in = s_tvalid;
      end
      rbia_pkg::ST_REL_RD:  cmd.rel_rd     = stat.in_window;
      rbia_pkg::ST_REL_WR:  cmd.rel_commit = 1'b1;
      rbia_pkg::ST_SCAN_RD: cmd.scan_rd    = 1'b1;
      rbia_pkg::ST_SCAN_CHK: begin
        cmd.scan_commit = stat.scan_hit;
        cmd.scan_next   = !stat.scan_hit && !stat.scan_last;
      end
      rbia_pkg::ST_ALLOC:  cmd.alloc_commit = 1'b1;
      rbia_pkg::ST_FINISH: cmd.out_load     = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/range_bitmap_id_allocator.sv =====
// Identifier allocator. Allocated ids form a window [low, high); an id
// released from inside the window is kept as a free mark in a row-organized
// mark RAM (32 ids per row) and a fragmented flag is raised. An allocate
// first reuses the lowest marked id inside the window while the flag is set
// (clearing the flag once the scan finds none), then grows the window
// downward, then upward below min(id_limit, MAX_IDS), and otherwise answers
// with status 1 (exhausted) and id 0. A release shrinks the window at either
// end, marks an interior id free, and ignores an id outside the window.
// Every input transfer gives exactly one output transfer.
// After reset the mark RAM is cleared one row per cycle, with s_tready
// low. One item is worked on at a time. A release inside the window reads
// its mark row and then writes it back; a release outside it goes straight
// to the result load; an allocate without a scan updates the window; a
// scanning allocate reads and then tests each mark row in turn, from the
// window's low end up to the first row holding a mark, or to the high end,
// and updates the window when no row holds one. s_tready comes back in the
// cycle after the load.
// The result sits in an output register, so the next input transfer is
// taken while it waits on m_tready.
// id_limit may be written only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module range_bitmap_id_allocator #(
  parameter int MAX_IDS = rbia_pkg::MAX_IDS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [rbia_pkg::TDATA_W-1:0]  s_tdata,   // [9:0] release_id, rest zero
  input  wire logic [0:0]                    s_tuser,   // [0] kind: 0 allocate, 1 release
  // output stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [rbia_pkg::TDATA_W-1:0]  m_tdata,   // [9:0] granted_id, rest zero
  output logic      [0:0]                    m_tuser,   // [0] status: 1 exhausted
  // id_limit register
  input  wire logic                          cfg_we,
  input  wire logic [rbia_pkg::LIMIT_W-1:0]  cfg_wdata
);

  rbia_pkg::cmd_t  cmd;
  rbia_pkg::stat_t stat;

  // sequencing: clear pass, release read-modify-write, row scan, window update
  rbia_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // window registers, limit, mark RAM, scan logic and output register
  rbia_dp #(
    .MAX_IDS (MAX_IDS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import rbia_pkg::*;

  localparam int NUM_IDS   = 1024;
  localparam int STALL_MAX = 5000;  // cycles with no transfer before giving up
  localparam int LONG_HOLD = 400;   // receiver hold-off that backs up the block
  localparam int PAD_W     = TDATA_W - ID_W;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_RELEASE,
    OP_SETLIM
  } step_op_t;

  typedef struct packed {
    logic [ID_W-1:0] gid;
    logic            st;
  } grant_t;

  typedef struct {
    step_op_t          op;
    logic [LIMIT_W-1:0] arg;    // release id or new limit
    bit                typed;  // expected result given in the row
    logic [ID_W-1:0]   gid;
    logic              st;
  } plan_row_t;

  // DUT signals; every input has a known value from time zero
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [TDATA_W-1:0]   s_tdata = '0;
  logic [0:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [TDATA_W-1:0]   m_tdata;
  logic [0:0]           m_tuser;
  logic                 cfg_we = 1'b0;
  logic [LIMIT_W-1:0]   cfg_wdata = '0;

  range_bitmap_id_allocator #(.MAX_IDS(NUM_IDS)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Allocator model state
  logic [LIMIT_W-1:0] lim_reg;
  logic [LIMIT_W-1:0] win_lo;
  logic [LIMIT_W-1:0] win_hi;
  logic               frag_pending;
  bit                 free_mark [NUM_IDS];

  grant_t    grants_due [$];
  plan_row_t plan [$];

  int  errors    = 0;
  int  n_alloc   = 0;
  int  n_release = 0;
  int  n_reuse   = 0;
  int  n_exhaust = 0;
  int  n_results = 0;
  int  max_span  = 0;
  int  n_holds   = 0;
  bit  quiet     = 1'b0;  // no idling on either side
  bit  hold_req  = 1'b0;  // asks the receiver for one long hold-off
  bit  xfer_seen;

  // ---------------------------------------------------------------------
  // Model: one input transfer in, the result it should produce out
  // ---------------------------------------------------------------------
  task automatic model_step(input logic kind, input logic [ID_W-1:0] rid,
                            output grant_t g);
    int  i;
    bit  found;
    int  eff;
    g.gid = '0;
    g.st  = STATUS_OK;
    found = 1'b0;
    eff   = (lim_reg > NUM_IDS) ? NUM_IDS : int'(lim_reg);
    if (kind == KIND_ALLOC) begin
      n_alloc++;
      // reuse the lowest marked id first
      if (frag_pending) begin
        i = int'(win_lo);
        while (!found && i < win_hi && i < NUM_IDS) begin
          if (free_mark[i]) begin
            free_mark[i] = 1'b0;
            g.gid = i[ID_W-1:0];
            found = 1'b1;
            n_reuse++;
          end
          i++;
        end
        if (!found) frag_pending = 1'b0;
      end
      if (!found) begin
        if (win_lo > 0) begin
          win_lo = win_lo - 1'b1;
          free_mark[win_lo] = 1'b0;
          g.gid = win_lo[ID_W-1:0];
        end else if (win_hi < eff) begin
          free_mark[win_hi] = 1'b0;
          g.gid  = win_hi[ID_W-1:0];
          win_hi = win_hi + 1'b1;
        end else begin
          g.st = STATUS_EXHAUSTED;
          n_exhaust++;
        end
      end
    end else begin
      n_release++;
      // ids outside the window are dropped silently
      if (rid >= win_lo && rid < win_hi) begin
        if (rid == win_lo) begin
          free_mark[rid] = 1'b0;
          win_lo = win_lo + 1'b1;
        end else if (rid + 1 == win_hi) begin
          free_mark[rid] = 1'b0;
          win_hi = {1'b0, rid};
        end else begin
          free_mark[rid] = 1'b1;
          frag_pending   = 1'b1;
        end
      end
    end
    if (int'(win_hi) - int'(win_lo) > max_span) max_span = int'(win_hi) - int'(win_lo);
  endtask

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------
  // Offer one item, hold it until the transfer, then queue what it should give.
  // Returns in the time step of the accepting edge with s_tvalid still high.
  task automatic offer(input logic kind, input logic [ID_W-1:0] rid,
                       input bit typed, input grant_t typed_g);
    grant_t g;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{PAD_W{1'b0}}, rid};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    model_step(kind, rid, g);
    grants_due.push_back(typed ? typed_g : g);
  endtask

  task automatic sender_gap(input int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain;
    s_tvalid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Limit writes only happen with nothing in flight
  task automatic set_limit(input logic [LIMIT_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    lim_reg  = v;
  endtask

  task automatic add_row(input step_op_t op, input logic [LIMIT_W-1:0] arg,
                         input bit typed = 1'b0, input logic [ID_W-1:0] gid = '0,
                         input logic st = STATUS_OK);
    plan_row_t r;
    r.op    = op;
    r.arg   = arg;
    r.typed = typed;
    r.gid   = gid;
    r.st    = st;
    plan.push_back(r);
  endtask

  // Random traffic: alloc_pct sets how fast the window grows. Releases mostly
  // hit the window ends or its inside; the rest are arbitrary ids.
  task automatic run_phase(input int n_items, input int alloc_pct, input int hold_at,
                           input int drain_at);
    int              k;
    int              pick;
    logic            kind;
    logic [ID_W-1:0] rid;
    grant_t          none;
    none = '0;
    for (k = 0; k < n_items; k++) begin
      if (k == hold_at) hold_req = 1'b1;
      if (k == drain_at) drain();
      if (!quiet && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 19));
      kind = ($urandom_range(0, 99) < alloc_pct) ? KIND_ALLOC : KIND_RELEASE;
      rid  = ID_W'($urandom_range(0, NUM_IDS - 1));
      if (kind == KIND_RELEASE && win_hi > win_lo) begin
        pick = $urandom_range(0, 99);
        if (pick < 20)      rid = win_lo[ID_W-1:0];
        else if (pick < 40) rid = win_hi[ID_W-1:0] - 1'b1;
        else if (pick < 75) rid = ID_W'($urandom_range(int'(win_lo), int'(win_hi) - 1));
      end
      offer(kind, rid, 1'b0, none);
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver side: random back-pressure plus one long hold-off on request
  // ---------------------------------------------------------------------
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        n_holds++;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: each output transfer against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    grant_t want;
    xfer_seen <= (s_tvalid && s_tready) || (m_tvalid && m_tready);
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (grants_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected result: id=%0d status=%0d", $realtime,
                   m_tdata, m_tuser);
      end else begin
        want = grants_due.pop_front();
        if (m_tdata !== {{PAD_W{1'b0}}, want.gid} || m_tuser[0] !== want.st) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] result mismatch: id exp %0d got %0d, status exp %0d got %0d",
                     $realtime, want.gid, m_tdata, want.st, m_tuser);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  initial begin : watchdog
    int stall_cnt;
    stall_cnt = 0;
    while (stall_cnt < STALL_MAX) begin
      @(posedge clk);
      if (xfer_seen) stall_cnt = 0;
      else stall_cnt++;
    end
    $display("Timeout: no transfer for %0d cycles", STALL_MAX);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : main_seq
    int     r;
    int     i;
    grant_t tg;
    lim_reg      = LIMIT_W'(ID_LIMIT_RST);
    win_lo       = '0;
    win_hi       = '0;
    frag_pending = 1'b0;
    for (i = 0; i < NUM_IDS; i++) free_mark[i] = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // mark store is cleared after reset; input stays closed until done
    @(posedge clk);
    while (!s_tready) @(posedge clk);

    // Directed table; typed rows carry results obvious from the window state
    add_row(OP_RELEASE, 11'd0,    1'b1, 10'd0, STATUS_OK);    // empty window
    add_row(OP_RELEASE, 11'd1023, 1'b1, 10'd0, STATUS_OK);
    add_row(OP_ALLOC,   11'd1023, 1'b1, 10'd0, STATUS_OK);    // first id
    add_row(OP_ALLOC,   11'd0,    1'b1, 10'd1, STATUS_OK);
    add_row(OP_ALLOC,   11'd0);
    add_row(OP_ALLOC,   11'd0);                               // window [0,4)
    add_row(OP_RELEASE, 11'd0,    1'b1, 10'd0, STATUS_OK);    // low end shrinks
    add_row(OP_ALLOC,   11'd0);                               // grows down again
    add_row(OP_RELEASE, 11'd3);                               // top end shrinks
    add_row(OP_RELEASE, 11'd1);                               // interior mark
    add_row(OP_ALLOC,   11'd0);                               // reuses the mark
    add_row(OP_ALLOC,   11'd0);                               // empty scan, grows up
    add_row(OP_RELEASE, 11'd2);
    add_row(OP_RELEASE, 11'd1);
    add_row(OP_ALLOC,   11'd0);
    add_row(OP_ALLOC,   11'd0);
    add_row(OP_SETLIM,  11'd0);                               // limit zero
    add_row(OP_ALLOC,   11'd0,    1'b1, 10'd0, STATUS_EXHAUSTED);
    add_row(OP_RELEASE, 11'd3,    1'b1, 10'd0, STATUS_OK);    // still shrinks
    add_row(OP_RELEASE, 11'd0,    1'b1, 10'd0, STATUS_OK);
    add_row(OP_ALLOC,   11'd0);
    add_row(OP_SETLIM,  11'd2047);                            // above MAX_IDS
    add_row(OP_ALLOC,   11'd0);
    add_row(OP_SETLIM,  11'd1);                               // limit below window
    add_row(OP_ALLOC,   11'd0,    1'b1, 10'd0, STATUS_EXHAUSTED);
    add_row(OP_SETLIM,  11'd1024);

    for (r = 0; r < plan.size(); r++) begin
      if (plan[r].op == OP_SETLIM) begin
        set_limit(plan[r].arg);
      end else begin
        tg.gid = plan[r].gid;
        tg.st  = plan[r].st;
        offer((plan[r].op == OP_ALLOC) ? KIND_ALLOC : KIND_RELEASE,
              plan[r].arg[ID_W-1:0], plan[r].typed, tg);
      end
    end

    // Random phases: grow deep, then squeeze with small and zero limits
    run_phase(400, 80, -1, 200);                    // pause for all results midway
    set_limit(11'd2047);
    run_phase(300, 50, 50, -1);                     // long receiver hold-off
    set_limit(LIMIT_W'($urandom_range(3, 40)));
    run_phase(250, 55, -1, -1);
    set_limit(11'd0);
    run_phase(150, 40, -1, -1);
    set_limit(11'd1);
    run_phase(150, 50, -1, -1);
    set_limit(LIMIT_W'($urandom_range(1, 1024)));
    run_phase(300, 55, -1, -1);
    set_limit(11'd1024);
    quiet = 1'b1;                                   // back-to-back to the end
    run_phase(350, 60, -1, -1);

    s_tvalid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (grants_due.size() != 0) errors++;

    $display("Covered %0d allocates (%0d reused marks, %0d exhausted) and %0d releases",
             n_alloc, n_reuse, n_exhaust, n_release);
    $display("Widest window %0d ids, %0d results checked, %0d long hold-offs, %0d errors",
             max_span, n_results, n_holds, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/rbia_pkg.sv
rtl/core/rbia_ram.sv
rtl/core/rbia_dp.sv
rtl/core/rbia_ctrl.sv
rtl/core/range_bitmap_id_allocator.sv
verif/tb_top.sv
